// ===== sv/frnc_pkg.sv =====
package frnc_pkg;

    typedef enum logic [1:0] {
        VERDICT_SAME  = 2'd0,
        VERDICT_WRITE = 2'd1,
        VERDICT_ERASE = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CLS_SAME  = 2'd0,
        CLS_WRITE = 2'd1,
        CLS_ERASE = 2'd2
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } byte_info_t;

    localparam int DIFF_W = 16;

    typedef struct packed {
        verdict_t            verdict;
        logic [DIFF_W-1:0]   first_diff;
        logic [DIFF_W-1:0]   last_diff;
    } result_t;

endpackage

// ===== sv/frnc_queue.sv =====
module frnc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    // DEPTH is a power of two, so the pointers wrap on their own.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on a lone push");

endmodule

// ===== sv/frnc_front.sv =====
module frnc_front #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              flash_byte,
    input  logic [7:0]              wanted_byte,
    input  logic                    last_byte,
    input  logic                    q_full,
    output logic                    q_push,
    output frnc_pkg::byte_info_t    q_info,
    output logic [OFFSET_WIDTH-1:0] q_offset
);

    import frnc_pkg::*;

    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [OFFSET_WIDTH-1:0] offset_next;
    logic                    accept;
    byte_class_t             cls;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // A byte is program-only when programming only has to clear flash bits.
    always_comb
    begin
        if (flash_byte == wanted_byte)
        begin
            cls = CLS_SAME;
        end
        else if ((wanted_byte & flash_byte) == wanted_byte)
        begin
            cls = CLS_WRITE;
        end
        else
        begin
            cls = CLS_ERASE;
        end
    end

    assign q_info.cls  = cls;
    assign q_info.last = last_byte;
    assign q_offset    = offset_reg;

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                offset_next = '0;
            end
            else if (offset_reg != '1)
            begin
                offset_next = offset_reg + OFFSET_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte && offset_reg != '1
        |=> offset_reg == $past(offset_reg) + OFFSET_WIDTH'(1))
        else $error("offset did not advance");

    a_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> offset_reg == '0)
        else $error("offset not cleared after the final byte");

endmodule

// ===== sv/frnc_back.sv =====
module frnc_back #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_empty,
    output logic                    in_pop,
    input  frnc_pkg::byte_info_t    in_info,
    input  logic [OFFSET_WIDTH-1:0] in_offset,
    input  logic                    out_full,
    output logic                    out_push,
    output frnc_pkg::result_t       out_result
);

    import frnc_pkg::*;

    verdict_t                run_verdict_reg;
    verdict_t                run_verdict_next;
    logic [OFFSET_WIDTH-1:0] first_reg;
    logic [OFFSET_WIDTH-1:0] first_next;
    logic [OFFSET_WIDTH-1:0] last_reg;
    logic [OFFSET_WIDTH-1:0] last_next;
    logic [31:0]             first_wide;
    logic [31:0]             last_wide;

    // Stalling on a full result queue keeps every transaction in order.
    assign in_pop   = !in_empty && !out_full;
    assign out_push = in_pop && in_info.last;

    always_comb
    begin
        run_verdict_next = run_verdict_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        // Once an erase is needed the rest of the run changes nothing.
        if (run_verdict_reg != VERDICT_ERASE)
        begin
            case (in_info.cls)
                CLS_WRITE:
                begin
                    if (run_verdict_reg == VERDICT_SAME)
                    begin
                        first_next       = in_offset;
                        run_verdict_next = VERDICT_WRITE;
                    end
                    last_next = in_offset;
                end
                CLS_ERASE:
                begin
                    first_next       = in_offset;
                    run_verdict_next = VERDICT_ERASE;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign first_wide = 32'(first_next);
    assign last_wide  = 32'(last_next);

    assign out_result.verdict    = run_verdict_next;
    assign out_result.first_diff = first_wide[DIFF_W-1:0];
    assign out_result.last_diff  = last_wide[DIFF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_verdict_reg <= VERDICT_SAME;
            first_reg       <= '0;
            last_reg        <= '0;
        end
        else if (in_pop)
        begin
            if (in_info.last)
            begin
                run_verdict_reg <= VERDICT_SAME;
                first_reg       <= '0;
                last_reg        <= '0;
            end
            else
            begin
                run_verdict_reg <= run_verdict_next;
                first_reg       <= first_next;
                last_reg        <= last_next;
            end
        end
    end

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop && in_info.last
        |=> run_verdict_reg == VERDICT_SAME && first_reg == '0 && last_reg == '0)
        else $error("run state not cleared after a result");

    a_erase_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        run_verdict_reg == VERDICT_ERASE && !(in_pop && in_info.last)
        |=> run_verdict_reg == VERDICT_ERASE && $stable(first_reg) && $stable(last_reg))
        else $error("run state changed after an erase verdict");

endmodule

// ===== sv/flash_rewrite_need_check.sv =====
// Path: a byte pair accepted by the front is registered in the middle queue, then popped by
// the back into the run accumulator; its final byte's pop writes the result into the result queue.
// Throughput: one byte pair per cycle unless a full queue stalls the input, with a combinational
// classify step; two-entry queues between the front, the back and the result side.
// Reset: rst_n clears the queues, the offset counter and the run state at once.
module flash_rewrite_need_check #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  flash_byte,
    input  logic [7:0]  wanted_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  verdict,
    output logic [15:0] first_diff,
    output logic [15:0] last_diff
);

    import frnc_pkg::*;

    localparam int INFO_W = $bits(byte_info_t);
    localparam int MID_W  = INFO_W + OFFSET_WIDTH;
    localparam int RES_W  = $bits(result_t);

    logic                    mid_push;
    logic                    mid_full;
    logic                    mid_pop;
    logic                    mid_empty;
    byte_info_t              front_info;
    logic [OFFSET_WIDTH-1:0] front_offset;
    logic [MID_W-1:0]        mid_rdata;
    byte_info_t              back_info;
    logic [OFFSET_WIDTH-1:0] back_offset;
    logic                    res_push;
    logic                    res_full;
    result_t                 back_result;
    logic [RES_W-1:0]        res_rdata;
    result_t                 head_result;

    frnc_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .flash_byte  (flash_byte),
        .wanted_byte (wanted_byte),
        .last_byte   (last_byte),
        .q_full      (mid_full),
        .q_push      (mid_push),
        .q_info      (front_info),
        .q_offset    (front_offset)
    );

    frnc_queue #(
        .WIDTH (MID_W),
        .DEPTH (2)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata ({front_info, front_offset}),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_info   = byte_info_t'(mid_rdata[OFFSET_WIDTH +: INFO_W]);
    assign back_offset = mid_rdata[OFFSET_WIDTH-1:0];

    frnc_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_empty   (mid_empty),
        .in_pop     (mid_pop),
        .in_info    (back_info),
        .in_offset  (back_offset),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_result (back_result)
    );

    frnc_queue #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_result),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign head_result = result_t'(res_rdata);
    assign verdict     = head_result.verdict;
    assign first_diff  = head_result.first_diff;
    assign last_diff   = head_result.last_diff;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import frnc_pkg::*;

    localparam int OFS_W           = 16;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int HOLD_CYCLES     = 80;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {
        RUN_SAME,
        RUN_WRITE,
        RUN_MIXED,
        RUN_NOISE
    } run_mode_t;

    class need_check_board;
        logic [OFS_W-1:0] run_offset;
        verdict_t         run_class;
        logic [OFS_W-1:0] first_ofs;
        logic [OFS_W-1:0] last_ofs;
        result_t          pending_verdicts[$];
        int               errors;
        int               bytes_seen;
        int               verdict_tally[3];

        function new();
            clear_run();
            errors = 0;
            bytes_seen = 0;
            foreach (verdict_tally[i]) verdict_tally[i] = 0;
        endfunction

        function void clear_run();
            run_offset = '0;
            run_class = VERDICT_SAME;
            first_ofs = '0;
            last_ofs = '0;
        endfunction

        function void take_byte(logic [7:0] fb, logic [7:0] wb, logic lst);
            result_t r;
            bytes_seen++;
            // Once a run needs an erase, only the end-of-run mark matters.
            if (run_class != VERDICT_ERASE && fb != wb) begin
                if ((wb & fb) == wb) begin
                    if (run_class == VERDICT_SAME) begin
                        first_ofs = run_offset;
                        run_class = VERDICT_WRITE;
                    end
                    last_ofs = run_offset;
                end
                else begin
                    first_ofs = run_offset;
                    run_class = VERDICT_ERASE;
                end
            end
            if (lst) begin
                r.verdict = run_class;
                r.first_diff = first_ofs;
                r.last_diff = last_ofs;
                pending_verdicts.push_back(r);
                clear_run();
            end
            else if (run_offset != '1) begin
                run_offset++;
            end
        endfunction

        function void check_verdict(logic [1:0] v, logic [15:0] f, logic [15:0] l);
            result_t exp;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result: verdict %0d first_diff %0d last_diff %0d",
                         $time, v, f, l);
                errors++;
                return;
            end
            exp = pending_verdicts.pop_front();
            verdict_tally[exp.verdict]++;
            if (v !== exp.verdict) begin
                $display("%0t: verdict mismatch: expected %0d, actual %0d",
                         $time, exp.verdict, v);
                errors++;
            end
            if (f !== exp.first_diff) begin
                $display("%0t: first_diff mismatch: expected %0d, actual %0d",
                         $time, exp.first_diff, f);
                errors++;
            end
            if (l !== exp.last_diff) begin
                $display("%0t: last_diff mismatch: expected %0d, actual %0d",
                         $time, exp.last_diff, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  flash_byte = 8'h00;
    logic [7:0]  wanted_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  verdict;
    logic [15:0] first_diff;
    logic [15:0] last_diff;

    need_check_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    flash_rewrite_need_check #(
        .OFFSET_WIDTH(OFS_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .flash_byte(flash_byte),
        .wanted_byte(wanted_byte),
        .last_byte(last_byte),
        .empty(empty),
        .pop(pop),
        .verdict(verdict),
        .first_diff(first_diff),
        .last_diff(last_diff)
    );

    always #1 clk = ~clk;

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, board.pending_verdicts.size());
                $display("FAIL flash_rewrite_need_check");
                $finish;
            end
        end
    end

    // Result side: checks each popped transaction, then picks the next pop value.
    initial
    begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                board.check_verdict(verdict, first_diff, last_diff);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] fb, input logic [7:0] wb, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        flash_byte <= fb;
        wanted_byte <= wb;
        last_byte <= lst;
        do @(posedge clk); while (full);
        board.take_byte(fb, wb, lst);
    endtask

    function automatic void make_pair(input run_mode_t mode, output logic [7:0] fb,
                                      output logic [7:0] wb);
        int roll;
        roll = $urandom_range(99);
        fb = 8'($urandom_range(255));
        wb = fb;
        case (mode)
            RUN_SAME: ;
            RUN_WRITE: if (roll < 40) wb = fb & 8'($urandom_range(255));
            RUN_MIXED:
            begin
                if (roll < 35)
                    wb = fb & 8'($urandom_range(255));
                else if (roll < 50)
                    wb = 8'($urandom_range(255));
            end
            RUN_NOISE: wb = 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_run(input int len, input run_mode_t mode);
        logic [7:0] fb;
        logic [7:0] wb;
        for (int i = 0; i < len; i++) begin
            make_pair(mode, fb, wb);
            send_byte(fb, wb, i == len - 1);
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle);
        int start;
        int roll;
        int len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        // Hold the result side off while one-byte runs keep coming, so the
        // internal queues fill up and the block has to raise full.
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_run(1, run_mode_t'($urandom_range(3)));
        start = board.bytes_seen;
        while (board.bytes_seen - start < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 80)
                len = $urandom_range(8, 1);
            else if (roll < 97)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(120, 41);
            send_run(len, run_mode_t'($urandom_range(3)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 46;
        // Single-byte runs of each verdict and the all-ones and all-zeros bytes.
        send_byte(8'h00, 8'h00, 1'b1);
        send_byte(8'hFF, 8'h00, 1'b1);
        send_byte(8'h00, 8'hFF, 1'b1);
        send_byte(8'hFF, 8'hFF, 1'b1);
        // Program-only differences separated by identical bytes.
        send_byte(8'hAA, 8'hAA, 1'b0);
        send_byte(8'hFF, 8'h0F, 1'b0);
        send_byte(8'h55, 8'h55, 1'b0);
        send_byte(8'hF0, 8'h80, 1'b1);
        // Erase after program-only differences, with bytes after the erase.
        send_byte(8'hFF, 8'hFE, 1'b0);
        send_byte(8'h0F, 8'h07, 1'b0);
        send_byte(8'h01, 8'h02, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b0);
        send_byte(8'h00, 8'hFF, 1'b1);
        send_byte(8'h5A, 8'h5A, 1'b0);
        send_byte(8'hA5, 8'hA5, 1'b1);

        run_phase(32, 46);
        run_phase(46, 32);
        run_phase(0, 0);
        push <= 1'b0;

        while (board.pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d byte pairs: %0d identical, %0d program-only, %0d erase runs.",
                 board.bytes_seen, board.verdict_tally[VERDICT_SAME],
                 board.verdict_tally[VERDICT_WRITE], board.verdict_tally[VERDICT_ERASE]);
        $display("Three idling mixes with a result hold-off in each that backs up the input.");
        if (board.errors == 0)
            $display("PASS flash_rewrite_need_check");
        else
            $display("FAIL flash_rewrite_need_check");
        $finish;
    end

endmodule
